### design/eth_rxf_pkg.sv
// shared types, constants and the byte-wide crc-32 step for the receive filter
// no dependencies
`default_nettype none

package eth_rxf_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned VERDICT_W = 3;

  localparam logic [LEN_W-1:0]  LEN_MAX     = 11'd2047;
  localparam logic [LEN_W-1:0]  MIN_LEN_RST = 11'd46;
  localparam logic [15:0]       TYPE_IP     = 16'h0800;
  localparam logic [15:0]       TYPE_ARP    = 16'h0806;
  localparam logic [ADDR_W-1:0] BCAST_ADDR  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0]       CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0]       CRC_INIT    = 32'hFFFF_FFFF;

  // register index, taken from paddr bit 3
  localparam logic REG_STATION = 1'b0;
  localparam logic REG_MIN_LEN = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_IP        = 3'd0,
    VERDICT_ARP       = 3'd1,
    VERDICT_UNKNOWN   = 3'd2,
    VERDICT_NOT_FOR_ME = 3'd3,
    VERDICT_TOO_SHORT = 3'd4,
    VERDICT_BAD_FCS   = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] station_addr;
    logic [LEN_W-1:0]  min_len;
  } filt_cfg_t;

  typedef struct packed {
    logic              is_broadcast;
    logic [LEN_W-1:0]  frame_length;
    logic [VERDICT_W-1:0] verdict;
  } rx_result_t;

  // reflected crc-32 over one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/eth_rx_frame_filter.sv
// top level of the ethernet receive filter: register file, input stage and core
// depends on eth_rxf_pkg, eth_rxf_cfg, eth_rxf_in, eth_rxf_core
//
//   port group | dir  | beat contents
//   in_*       | in   | one frame byte, tlast on the final (fcs) byte
//   out_*      | out  | one verdict per frame, sent after its last byte
//   cfg_*      | both | station address at 0x0, minimum length at 0x8
//
// one byte per cycle sustained while no stalled result holds back a last byte; a
// byte sits in the input register and the crc step, header capture and verdict run
// between it and the result register, which offers the verdict once the last byte is taken.
// reset clears all frame state; the registers return to address 0 and length 46.
// a stalled result only holds back a following last byte, other bytes keep flowing.
`default_nettype none

module eth_rx_frame_filter
  import eth_rxf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [2:0] verdict, [13:3] frame_length, [14] is_broadcast
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  filt_cfg_t cfg;
  rx_beat_t  beat;
  logic      beat_valid;
  logic      beat_take;

  eth_rxf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  eth_rxf_in u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  eth_rxf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### design/eth_rxf_cfg.sv
// apb-style register file: station address and minimum frame length
// depends on eth_rxf_pkg
`default_nettype none

module eth_rxf_cfg
  import eth_rxf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready,
  output filt_cfg_t        cfg
);

  logic [ADDR_W-1:0] station_r;
  logic [LEN_W-1:0]  min_len_r;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
      min_len_r <= MIN_LEN_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3])
        REG_STATION: station_r <= cfg_pwdata[ADDR_W-1:0];
        REG_MIN_LEN: min_len_r <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      REG_STATION: cfg_prdata = {16'd0, station_r};
      REG_MIN_LEN: cfg_prdata = {53'd0, min_len_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.station_addr = station_r;
  assign cfg.min_len      = min_len_r;

endmodule

`default_nettype wire

### design/eth_rxf_in.sv
// input register stage: holds one received beat until the core takes it
// depends on eth_rxf_pkg
`default_nettype none

module eth_rxf_in
  import eth_rxf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  output logic            beat_valid,
  output rx_beat_t        beat,
  input  wire logic       beat_take
);

  logic     vld_r;
  logic     vld_nxt;
  rx_beat_t beat_r;
  logic     accept;

  // refill in the same cycle the core drains the register
  assign in_tready = !vld_r || beat_take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (beat_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r.data <= in_tdata;
      beat_r.last <= in_tlast;
    end
  end

  assign beat_valid = vld_r;
  assign beat       = beat_r;

endmodule

`default_nettype wire

### design/eth_rxf_core.sv
// per-frame state (crc, fcs delay line, count, header capture), verdict and result register
// depends on eth_rxf_pkg
`default_nettype none

module eth_rxf_core
  import eth_rxf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire filt_cfg_t   cfg,
  input  wire logic        beat_valid,
  input  wire rx_beat_t    beat,
  output logic             beat_take,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata
);

  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       tail_r, tail_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] dest_r, dest_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic              out_vld_r, out_vld_nxt;
  rx_result_t        res_r, res_nxt;
  logic [31:0]       fcs;
  logic              bcast;
  logic              done;

  // a last beat waits while an untaken result sits in the output register
  assign beat_take = beat_valid && (!beat.last || !out_vld_r || out_tready);
  assign done      = beat_take && beat.last;

  always_comb begin
    // byte leaving the four-byte delay line is covered by the crc, the fcs is not
    crc_nxt   = (cnt_r >= 11'd4) ? crc_byte(crc_r, tail_r[31:24]) : crc_r;
    tail_nxt  = {tail_r[23:0], beat.data};
    cnt_nxt   = (cnt_r < LEN_MAX) ? cnt_r + 11'd1 : cnt_r;
    dest_nxt  = dest_r;
    etype_nxt = etype_r;
    for (int k = 0; k < 6; k++) begin
      if (cnt_r == LEN_W'(k)) begin
        dest_nxt[8*(5-k) +: 8] = beat.data;
      end
    end
    if (cnt_r == 11'd12) begin
      etype_nxt[15:8] = beat.data;
    end
    if (cnt_r == 11'd13) begin
      etype_nxt[7:0] = beat.data;
    end
  end

  // fcs goes out low byte first
  assign fcs   = {tail_nxt[7:0], tail_nxt[15:8], tail_nxt[23:16], tail_nxt[31:24]};
  assign bcast = (dest_nxt == BCAST_ADDR);

  always_comb begin
    res_nxt.frame_length = cnt_nxt;
    res_nxt.is_broadcast = bcast;
    if (cnt_nxt < cfg.min_len) begin
      res_nxt.verdict = VERDICT_TOO_SHORT;
    end else if (~crc_nxt != fcs) begin
      res_nxt.verdict = VERDICT_BAD_FCS;
    end else if (!bcast && dest_nxt != cfg.station_addr) begin
      res_nxt.verdict = VERDICT_NOT_FOR_ME;
    end else if (etype_nxt == TYPE_IP) begin
      res_nxt.verdict = VERDICT_IP;
    end else if (etype_nxt == TYPE_ARP) begin
      res_nxt.verdict = VERDICT_ARP;
    end else begin
      res_nxt.verdict = VERDICT_UNKNOWN;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (done) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      tail_r    <= '0;
      cnt_r     <= '0;
      dest_r    <= '0;
      etype_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (done) begin
        crc_r   <= CRC_INIT;
        tail_r  <= '0;
        cnt_r   <= '0;
        dest_r  <= '0;
        etype_r <= '0;
      end else if (beat_take) begin
        crc_r   <= crc_nxt;
        tail_r  <= tail_nxt;
        cnt_r   <= cnt_nxt;
        dest_r  <= dest_nxt;
        etype_r <= etype_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

`default_nettype wire
